// File: rtl/core/cta_pkg.sv
// shared constants and types for the consumer table with aging
// no dependencies; used by consumer_table_with_aging
`default_nettype none

package cta_pkg;

	// table geometry
	localparam int CAPACITY      = 16;
	localparam int CHANNEL_BYTES = 256;

	// port widths fixed by the item formats
	localparam int TIME_W   = 64;
	localparam int WORD_W   = 32;
	localparam int LEN_W    = 16;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 4;
	localparam int FREED_W  = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 64;

	// operation codes
	localparam logic [MODE_W-1:0] MODE_HELLO     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SWEEP     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_AGGREGATE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_DESC  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_CTRL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DESC_LONG = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CTRL_LONG = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STALE_LIMIT   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_INTERVAL  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEF_BYTES     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ABSENT_MARKER = 4'd3;

	// configuration reset values
	localparam logic [TIME_W-1:0] RST_STALE_LIMIT   = 64'd5000000000;
	localparam logic [WORD_W-1:0] RST_DEF_INTERVAL  = 32'd1000;
	localparam logic [WORD_W-1:0] RST_DEF_BYTES     = 32'd65536;
	localparam logic [WORD_W-1:0] RST_ABSENT_MARKER = 32'hFFFF_FFFF;

	// one table entry as held in the memory
	typedef struct packed {
		logic [WORD_W-1:0] client;
		logic [TIME_W-1:0] last_seen;
		logic              progress_ok;
		logic [WORD_W-1:0] interval;
		logic [WORD_W-1:0] bytes;
		logic [WORD_W-1:0] major;
	} entry_t;

endpackage

`default_nettype wire

// File: rtl/core/consumer_table_with_aging.sv
// consumer registry: valid bits in flops, entry payload in one synchronous memory
// depends on cta_pkg
//
// hello, sweep and aggregate each scan the table through the single memory read
// port, one entry per cycle. a hello with a bad channel request and the unused mode
// skip the scan and go straight to the finishing state.
// one item at a time; the next item is taken once the result sits in the output register.
// reset clears the valid bits and loads the register defaults; no clearing pass.
`default_nettype none

module consumer_table_with_aging #(
	parameter int CAPACITY = cta_pkg::CAPACITY
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [cta_pkg::MODE_W-1:0]        mode,
	input  wire logic [cta_pkg::TIME_W-1:0]        now_time,
	input  wire logic [cta_pkg::WORD_W-1:0]        client_id,
	input  wire logic                              wants_progress,
	input  wire logic [cta_pkg::WORD_W-1:0]        interval_wish,
	input  wire logic [cta_pkg::WORD_W-1:0]        bytes_wish,
	input  wire logic [cta_pkg::WORD_W-1:0]        major_wish,
	input  wire logic [cta_pkg::LEN_W-1:0]         desc_chan_len,
	input  wire logic [cta_pkg::WORD_W-1:0]        desc_stream,
	input  wire logic [cta_pkg::LEN_W-1:0]         ctrl_chan_len,
	input  wire logic [cta_pkg::WORD_W-1:0]        ctrl_stream,

	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [cta_pkg::STATUS_W-1:0]           status,
	output logic [cta_pkg::SLOT_W-1:0]             slot,
	output logic                                   desc_requested,
	output logic                                   ctrl_requested,
	output logic [cta_pkg::FREED_W-1:0]            freed_count,
	output logic [cta_pkg::WORD_W-1:0]             agg_interval,
	output logic [cta_pkg::WORD_W-1:0]             agg_bytes,
	output logic [cta_pkg::WORD_W-1:0]             agg_major,

	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cta_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [cta_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = cta_pkg::LEN_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q;

	// configuration registers
	logic [cta_pkg::TIME_W-1:0] stale_limit_q;
	logic [cta_pkg::WORD_W-1:0] def_interval_q;
	logic [cta_pkg::WORD_W-1:0] def_bytes_q;
	logic [cta_pkg::WORD_W-1:0] absent_q;

	// table storage
	logic [CAPACITY-1:0] valid_q;
	cta_pkg::entry_t     mem [CAPACITY];
	cta_pkg::entry_t     rd_entry_s1;
	cta_pkg::entry_t     wr_entry;

	// captured item
	logic [cta_pkg::MODE_W-1:0]   mode_q;
	logic [cta_pkg::TIME_W-1:0]   now_q;
	logic [cta_pkg::WORD_W-1:0]   id_q;
	logic                         want_q;
	logic [cta_pkg::WORD_W-1:0]   iv_wish_q;
	logic [cta_pkg::WORD_W-1:0]   by_wish_q;
	logic [cta_pkg::WORD_W-1:0]   mj_wish_q;
	logic                         dreq_q;
	logic                         creq_q;
	logic                         dlong_q;
	logic                         clong_q;
	logic                         bad_q;
	logic [cta_pkg::STATUS_W-1:0] bad_status_q;

	// scan control
	logic [CW-1:0] rd_cnt_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          pv_s1;
	logic [IW-1:0] pidx_s1;
	logic          pvalid;

	// scan results
	logic          found_q;
	logic [IW-1:0] match_q;
	logic          free_found_q;
	logic [IW-1:0] free_q;
	logic [CW-1:0] freed_q;
	logic [cta_pkg::WORD_W-1:0] agg_iv_q, agg_by_q, agg_mj_q;
	logic          has_iv_q, has_by_q, has_mj_q;

	// finishing
	logic          load;
	logic          commit;
	logic [IW-1:0] hello_idx;
	logic          accept;
	logic          d_bad, c_bad;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign d_bad = (desc_chan_len != '0) != (desc_stream != '0);
	assign c_bad = (ctrl_chan_len != '0) != (ctrl_stream != '0);

	assign rd_en   = (state_q == ST_SCAN) && (rd_cnt_q != CW'(CAPACITY));
	assign rd_addr = rd_cnt_q[IW-1:0];
	assign pvalid  = valid_q[pidx_s1];

	assign load   = (state_q == ST_FIN) && (!out_valid || out_ready);
	assign hello_idx = found_q ? match_q : free_q;
	assign commit = load && (mode_q == cta_pkg::MODE_HELLO) && !bad_q
		&& (found_q || free_found_q);

	always_comb begin
		wr_entry.client      = id_q;
		wr_entry.last_seen   = now_q;
		wr_entry.progress_ok = want_q;
		wr_entry.interval    = iv_wish_q;
		wr_entry.bytes       = by_wish_q;
		wr_entry.major       = mj_wish_q;
	end

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (commit) begin
			mem[hello_idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_s1 <= mem[rd_addr];
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q  <= cta_pkg::RST_STALE_LIMIT;
			def_interval_q <= cta_pkg::RST_DEF_INTERVAL;
			def_bytes_q    <= cta_pkg::RST_DEF_BYTES;
			absent_q       <= cta_pkg::RST_ABSENT_MARKER;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cta_pkg::REG_STALE_LIMIT: begin
					stale_limit_q <= cfg_data;
				end
				cta_pkg::REG_DEF_INTERVAL: begin
					def_interval_q <= cfg_data[cta_pkg::WORD_W-1:0];
				end
				cta_pkg::REG_DEF_BYTES: begin
					def_bytes_q <= cfg_data[cta_pkg::WORD_W-1:0];
				end
				cta_pkg::REG_ABSENT_MARKER: begin
					absent_q <= cfg_data[cta_pkg::WORD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// control: state, read counter, valid bits, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_cnt_q  <= '0;
			pv_s1     <= 1'b0;
			valid_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			pv_s1 <= rd_en;
			if (rd_en) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						if ((mode == cta_pkg::MODE_SWEEP) || (mode == cta_pkg::MODE_AGGREGATE)
							|| ((mode == cta_pkg::MODE_HELLO) && !d_bad && !c_bad)) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_SCAN: begin
					if (pv_s1 && (pidx_s1 == IW'(CAPACITY - 1))) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// stale entries drop out as the sweep passes them
			if ((state_q == ST_SCAN) && pv_s1 && (mode_q == cta_pkg::MODE_SWEEP) && pvalid
				&& ((now_q - rd_entry_s1.last_seen) > stale_limit_q)) begin
				valid_q[pidx_s1] <= 1'b0;
			end
			if (commit && !found_q) begin
				valid_q[hello_idx] <= 1'b1;
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// payload: captured item, scan accumulators, result register
	always_ff @(posedge clk) begin
		if (rd_en) begin
			pidx_s1 <= rd_addr;
		end
		if (accept) begin
			mode_q    <= mode;
			now_q     <= now_time;
			id_q      <= client_id;
			want_q    <= wants_progress;
			iv_wish_q <= interval_wish;
			by_wish_q <= bytes_wish;
			mj_wish_q <= major_wish;
			dreq_q    <= (desc_chan_len != '0);
			creq_q    <= (ctrl_chan_len != '0);
			dlong_q   <= ({1'b0, desc_chan_len} >= LW'(cta_pkg::CHANNEL_BYTES));
			clong_q   <= ({1'b0, ctrl_chan_len} >= LW'(cta_pkg::CHANNEL_BYTES));
			bad_q     <= (mode == cta_pkg::MODE_HELLO) && (d_bad || c_bad);
			bad_status_q <= d_bad ? cta_pkg::ST_BAD_DESC : cta_pkg::ST_BAD_CTRL;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			match_q      <= '0;
			free_q       <= '0;
			freed_q      <= '0;
			agg_iv_q     <= def_interval_q;
			agg_by_q     <= def_bytes_q;
			agg_mj_q     <= '0;
			has_iv_q     <= 1'b0;
			has_by_q     <= 1'b0;
			has_mj_q     <= 1'b0;
		end else if ((state_q == ST_SCAN) && pv_s1) begin
			case (mode_q)
				cta_pkg::MODE_HELLO: begin
					if (!found_q && pvalid && (rd_entry_s1.client == id_q)) begin
						found_q <= 1'b1;
						match_q <= pidx_s1;
					end
					if (!free_found_q && !pvalid) begin
						free_found_q <= 1'b1;
						free_q       <= pidx_s1;
					end
				end
				cta_pkg::MODE_SWEEP: begin
					if (pvalid && ((now_q - rd_entry_s1.last_seen) > stale_limit_q)) begin
						freed_q <= freed_q + 1'b1;
					end
				end
				cta_pkg::MODE_AGGREGATE: begin
					if (pvalid && rd_entry_s1.progress_ok) begin
						if ((rd_entry_s1.interval != absent_q)
							&& (!has_iv_q || (rd_entry_s1.interval < agg_iv_q))) begin
							agg_iv_q <= rd_entry_s1.interval;
						end
						if ((rd_entry_s1.bytes != absent_q)
							&& (!has_by_q || (rd_entry_s1.bytes < agg_by_q))) begin
							agg_by_q <= rd_entry_s1.bytes;
						end
						if ((rd_entry_s1.major != absent_q)
							&& (!has_mj_q || (rd_entry_s1.major < agg_mj_q))) begin
							agg_mj_q <= rd_entry_s1.major;
						end
						if (rd_entry_s1.interval != absent_q) has_iv_q <= 1'b1;
						if (rd_entry_s1.bytes != absent_q) has_by_q <= 1'b1;
						if (rd_entry_s1.major != absent_q) has_mj_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		if (load) begin
			status         <= cta_pkg::ST_OK;
			slot           <= '0;
			desc_requested <= 1'b0;
			ctrl_requested <= 1'b0;
			freed_count    <= '0;
			agg_interval   <= '0;
			agg_bytes      <= '0;
			agg_major      <= '0;
			case (mode_q)
				cta_pkg::MODE_HELLO: begin
					if (bad_q) begin
						status <= bad_status_q;
					end else begin
						desc_requested <= dreq_q;
						ctrl_requested <= creq_q;
						if (!found_q && !free_found_q) begin
							status <= cta_pkg::ST_FULL;
						end else begin
							slot <= cta_pkg::SLOT_W'(hello_idx);
							if (dlong_q) begin
								status <= cta_pkg::ST_DESC_LONG;
							end else if (clong_q) begin
								status <= cta_pkg::ST_CTRL_LONG;
							end
						end
					end
				end
				cta_pkg::MODE_SWEEP: begin
					freed_count <= cta_pkg::FREED_W'(freed_q);
				end
				cta_pkg::MODE_AGGREGATE: begin
					agg_interval <= agg_iv_q;
					agg_bytes    <= agg_by_q;
					agg_major    <= agg_mj_q;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire
